@@ rtl/ttw_pkg.sv @@
// ----------------------------------------------------------------------------
// ttw_pkg : shared types and constants of the text terminal writer
// Field widths, operation codes, character codes, controller states and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ttw_pkg;

  localparam int OP_W    = 3;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int COORD_W = 8;
  localparam int COL_W   = 7;
  localparam int LINE_W  = 5;
  localparam int CELL_W  = 16;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  // operation codes; the remaining codes change nothing
  localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADVANCE,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_HOME,
    CUR_SET
  } cur_op_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_INIT,
    MEM_PUT,
    MEM_BLANK_BACK,
    MEM_READ,
    MEM_SCROLL,
    MEM_FILL
  } mem_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_t;

  typedef struct packed {
    cur_op_t cur_op;
    mem_op_t mem_op;
    cnt_op_t cnt_op;
    logic    latch_item;
    logic    capture_word;
    logic    rd_direct;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_newline;
    logic            at_home;
    logic            last_col;
    logic            last_line;
    logic            cnt_last;
    logic            scroll_end;
  } sts_t;

endpackage

@@ rtl/ttw_if.sv @@
// ----------------------------------------------------------------------------
// ttw_if : item channels of the text terminal writer
// Valid/ready channels for operation items and for cursor/cell results.
// ----------------------------------------------------------------------------
interface ttw_in_if;
  logic                        valid;
  logic                        ready;
  logic [ttw_pkg::OP_W-1:0]    operation;
  logic [ttw_pkg::CHAR_W-1:0]  char_code;
  logic [ttw_pkg::COLOR_W-1:0] color;
  logic [ttw_pkg::COORD_W-1:0] column;
  logic [ttw_pkg::COORD_W-1:0] row;

  modport source (output valid, operation, char_code, color, column, row, input ready);
  modport sink   (input valid, operation, char_code, color, column, row, output ready);
endinterface

interface ttw_out_if;
  logic                       valid;
  logic                       ready;
  logic [ttw_pkg::COL_W-1:0]  cursor_col;
  logic [ttw_pkg::LINE_W-1:0] cursor_line;
  logic [ttw_pkg::CELL_W-1:0] cell_word;

  modport source (output valid, cursor_col, cursor_line, cell_word, input ready);
  modport sink   (input valid, cursor_col, cursor_line, cell_word, output ready);
endinterface

@@ rtl/ttw_ram.sv @@
// ----------------------------------------------------------------------------
// ttw_ram : generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ttw_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttw_ctrl : controller of the text terminal writer
// Sequences item acceptance, execution, screen passes and result hand-off.
// ----------------------------------------------------------------------------
module ttw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ttw_pkg::sts_t sts,
  output ttw_pkg::cmd_t cmd
);

  ttw_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            need_scroll;

  assign out_free    = !out_valid_r || out_ready;
  assign need_scroll = sts.is_newline ? sts.last_line : (sts.last_col && sts.last_line);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttw_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ttw_pkg::ST_INIT: begin
        if (sts.cnt_last) state_nxt = ttw_pkg::ST_IDLE;
      end
      ttw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ttw_pkg::ST_EXEC;
      end
      ttw_pkg::ST_EXEC: begin
        case (sts.op)
          ttw_pkg::OP_PUT: begin
            if (need_scroll)   state_nxt = ttw_pkg::ST_SCROLL;
            else if (out_free) state_nxt = ttw_pkg::ST_IDLE;
            else               state_nxt = ttw_pkg::ST_DONE;
          end
          ttw_pkg::OP_CLEAR: state_nxt = ttw_pkg::ST_FILL;
          ttw_pkg::OP_READ:  state_nxt = ttw_pkg::ST_RD_WAIT;
          default: begin
            state_nxt = out_free ? ttw_pkg::ST_IDLE : ttw_pkg::ST_DONE;
          end
        endcase
      end
      ttw_pkg::ST_RD_WAIT: begin
        state_nxt = out_free ? ttw_pkg::ST_IDLE : ttw_pkg::ST_DONE;
      end
      ttw_pkg::ST_SCROLL: begin
        if (sts.scroll_end) state_nxt = ttw_pkg::ST_FILL;
      end
      ttw_pkg::ST_FILL: begin
        if (sts.cnt_last) state_nxt = out_free ? ttw_pkg::ST_IDLE : ttw_pkg::ST_DONE;
      end
      ttw_pkg::ST_DONE: begin
        if (out_free) state_nxt = ttw_pkg::ST_IDLE;
      end
      default: state_nxt = ttw_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd.cur_op       = ttw_pkg::CUR_HOLD;
    cmd.mem_op       = ttw_pkg::MEM_NONE;
    cmd.cnt_op       = ttw_pkg::CNT_HOLD;
    cmd.latch_item   = 1'b0;
    cmd.capture_word = 1'b0;
    cmd.rd_direct    = 1'b0;
    cmd.load_out     = 1'b0;
    in_ready         = 1'b0;
    case (state_r)
      ttw_pkg::ST_INIT: begin
        cmd.mem_op = ttw_pkg::MEM_INIT;
        cmd.cnt_op = sts.cnt_last ? ttw_pkg::CNT_CLEAR : ttw_pkg::CNT_INC;
      end
      ttw_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.cnt_op     = ttw_pkg::CNT_CLEAR;
        cmd.latch_item = in_valid;
      end
      ttw_pkg::ST_EXEC: begin
        case (sts.op)
          ttw_pkg::OP_PUT: begin
            if (sts.is_newline) begin
              cmd.cur_op = ttw_pkg::CUR_NEWLINE;
            end else begin
              cmd.cur_op = ttw_pkg::CUR_ADVANCE;
              cmd.mem_op = ttw_pkg::MEM_PUT;
            end
            cmd.load_out = !need_scroll && out_free;
          end
          ttw_pkg::OP_REMOVE: begin
            if (!sts.at_home) begin
              cmd.cur_op = ttw_pkg::CUR_BACK;
              cmd.mem_op = ttw_pkg::MEM_BLANK_BACK;
            end
            cmd.load_out = out_free;
          end
          ttw_pkg::OP_CLEAR: cmd.cur_op = ttw_pkg::CUR_HOME;
          ttw_pkg::OP_SET: begin
            cmd.cur_op   = ttw_pkg::CUR_SET;
            cmd.load_out = out_free;
          end
          ttw_pkg::OP_READ: cmd.mem_op = ttw_pkg::MEM_READ;
          default: cmd.load_out = out_free;
        endcase
      end
      ttw_pkg::ST_RD_WAIT: begin
        cmd.capture_word = 1'b1;
        cmd.rd_direct    = 1'b1;
        cmd.load_out     = out_free;
      end
      ttw_pkg::ST_SCROLL: begin
        cmd.mem_op = ttw_pkg::MEM_SCROLL;
        cmd.cnt_op = sts.scroll_end ? ttw_pkg::CNT_HOLD : ttw_pkg::CNT_INC;
      end
      ttw_pkg::ST_FILL: begin
        cmd.mem_op   = ttw_pkg::MEM_FILL;
        cmd.cnt_op   = sts.cnt_last ? ttw_pkg::CNT_CLEAR : ttw_pkg::CNT_INC;
        cmd.load_out = sts.cnt_last && out_free;
      end
      ttw_pkg::ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd.cur_op = ttw_pkg::CUR_HOLD;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/ttw_dpath.sv @@
// ----------------------------------------------------------------------------
// ttw_dpath : datapath of the text terminal writer
// Item and cursor registers, cell addressing, pass counter, screen RAM and
// result registers.
// ----------------------------------------------------------------------------
module ttw_dpath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ttw_pkg::cmd_t               cmd,
  output ttw_pkg::sts_t               sts,
  input  logic [ttw_pkg::OP_W-1:0]    in_operation,
  input  logic [ttw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [ttw_pkg::COLOR_W-1:0] in_color,
  input  logic [ttw_pkg::COORD_W-1:0] in_column,
  input  logic [ttw_pkg::COORD_W-1:0] in_row,
  output logic [ttw_pkg::COL_W-1:0]   out_cursor_col,
  output logic [ttw_pkg::LINE_W-1:0]  out_cursor_line,
  output logic [ttw_pkg::CELL_W-1:0]  out_cell_word
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] COLS_A      = AW'(COLS);
  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_LAST = AW'(CELLS - COLS);

  localparam logic [ttw_pkg::COL_W-1:0]   COL_MAX  = ttw_pkg::COL_W'(COLS - 1);
  localparam logic [ttw_pkg::LINE_W-1:0]  LINE_MAX = ttw_pkg::LINE_W'(ROWS - 1);
  localparam logic [ttw_pkg::COORD_W-1:0] COLS_C   = ttw_pkg::COORD_W'(COLS);
  localparam logic [ttw_pkg::COORD_W-1:0] ROWS_C   = ttw_pkg::COORD_W'(ROWS);

  logic [ttw_pkg::OP_W-1:0]    op_r;
  logic [ttw_pkg::CHAR_W-1:0]  ch_r;
  logic [ttw_pkg::COLOR_W-1:0] color_r;
  logic [ttw_pkg::COORD_W-1:0] column_r;
  logic [ttw_pkg::COORD_W-1:0] row_r;

  logic [ttw_pkg::COL_W-1:0]   col_r, col_nxt, col_clamp, sel_col;
  logic [ttw_pkg::LINE_W-1:0]  line_r, line_nxt, line_clamp, sel_line;

  logic [AW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               cell_addr;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [ttw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;
  logic [ttw_pkg::CELL_W-1:0]  blank_cell;

  logic [ttw_pkg::CELL_W-1:0]  word_r;
  logic [ttw_pkg::COL_W-1:0]   out_col_r;
  logic [ttw_pkg::LINE_W-1:0]  out_line_r;
  logic [ttw_pkg::CELL_W-1:0]  out_word_r, out_word_nxt;

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      op_r     <= in_operation;
      ch_r     <= in_char_code;
      color_r  <= in_color;
      column_r <= in_column;
      row_r    <= in_row;
    end
  end

  assign col_clamp  = (column_r >= COLS_C) ? COL_MAX : column_r[ttw_pkg::COL_W-1:0];
  assign line_clamp = (row_r >= ROWS_C) ? LINE_MAX : row_r[ttw_pkg::LINE_W-1:0];
  assign blank_cell = {color_r, ttw_pkg::BLANK_CHAR};

  // cursor update
  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    case (cmd.cur_op)
      ttw_pkg::CUR_ADVANCE: begin
        if (col_r == COL_MAX) begin
          col_nxt = '0;
          if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ttw_pkg::CUR_NEWLINE: begin
        col_nxt = '0;
        if (line_r != LINE_MAX) line_nxt = line_r + 1'b1;
      end
      ttw_pkg::CUR_BACK: begin
        if (col_r != '0) begin
          col_nxt = col_r - 1'b1;
        end else begin
          col_nxt  = COL_MAX;
          line_nxt = line_r - 1'b1;
        end
      end
      ttw_pkg::CUR_HOME: begin
        col_nxt  = '0;
        line_nxt = '0;
      end
      ttw_pkg::CUR_SET: begin
        col_nxt  = col_clamp;
        line_nxt = line_clamp;
      end
      default: begin
        col_nxt  = col_r;
        line_nxt = line_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

  // one shared row-times-width address unit
  always_comb begin
    case (cmd.mem_op)
      ttw_pkg::MEM_BLANK_BACK: begin
        sel_col  = col_nxt;
        sel_line = line_nxt;
      end
      ttw_pkg::MEM_READ: begin
        sel_col  = col_clamp;
        sel_line = line_clamp;
      end
      default: begin
        sel_col  = col_r;
        sel_line = line_r;
      end
    endcase
  end

  assign cell_addr = AW'(sel_line) * COLS_A + AW'(sel_col);

  // pass counter
  always_comb begin
    case (cmd.cnt_op)
      ttw_pkg::CNT_CLEAR: cnt_nxt = '0;
      ttw_pkg::CNT_INC:   cnt_nxt = cnt_r + 1'b1;
      default:            cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = blank_cell;
    ram_raddr = '0;
    case (cmd.mem_op)
      ttw_pkg::MEM_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ttw_pkg::MEM_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr;
        ram_wdata = {color_r, ch_r};
      end
      ttw_pkg::MEM_BLANK_BACK: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr;
      end
      ttw_pkg::MEM_READ: begin
        ram_raddr = cell_addr;
      end
      ttw_pkg::MEM_SCROLL: begin
        // read one row ahead, write back the word fetched last cycle
        ram_raddr = (cnt_r != SCROLL_LAST) ? cnt_r + COLS_A : '0;
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_r - 1'b1;
        ram_wdata = ram_rdata;
      end
      ttw_pkg::MEM_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ttw_ram #(
    .WIDTH (ttw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture_word) word_r <= ram_rdata;
  end

  // result registers
  always_comb begin
    if (op_r == ttw_pkg::OP_READ) out_word_nxt = cmd.rd_direct ? ram_rdata : word_r;
    else                          out_word_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_col_r  <= col_nxt;
      out_line_r <= line_nxt;
      out_word_r <= out_word_nxt;
    end
  end

  assign out_cursor_col  = out_col_r;
  assign out_cursor_line = out_line_r;
  assign out_cell_word   = out_word_r;

  assign sts.op         = op_r;
  assign sts.is_newline = (ch_r == ttw_pkg::NEWLINE_CHAR);
  assign sts.at_home    = (col_r == '0) && (line_r == '0);
  assign sts.last_col   = (col_r == COL_MAX);
  assign sts.last_line  = (line_r == LINE_MAX);
  assign sts.cnt_last   = (cnt_r == LAST_CELL);
  assign sts.scroll_end = (cnt_r == SCROLL_LAST);

endmodule

@@ rtl/text_terminal_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_terminal_writer_core : text-mode character screen engine
// Cursor and COLS x ROWS cell store with put, remove, clear, set and read.
// ----------------------------------------------------------------------------
// A character screen of COLS x ROWS cell words (character in the low byte,
// colour in the high byte) held in a single RAM with one write and one
// registered read port, plus a cursor. Each accepted item returns exactly one
// result with the cursor after the operation and, for a read, the addressed
// cell. From acceptance to the next acceptance: put, newline without scroll,
// remove, set cursor and unused codes pass through accept, then execute; read
// adds a wait state for the registered RAM read.
// A put or newline that runs past the bottom row scrolls the screen one cell
// per cycle through the RAM: a copy pass moves each row up by one, then a
// fill pass blanks the bottom row. Clear fills every cell one per cycle.
// After reset a clearing pass writes zero to all COLS*ROWS cells before the
// first item is taken. Results sit in an output register, so the next item
// is taken while a result waits; an item finishing with the register still
// full holds until the result is taken.
module text_terminal_writer_core #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  ttw_in_if.sink    in_ch,
  ttw_out_if.source out_ch
);

  ttw_pkg::cmd_t cmd;
  ttw_pkg::sts_t sts;

  // sequence the item, hold the result until taken
  ttw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // cursor, addressing, screen store and result payload
  ttw_dpath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_char_code    (in_ch.char_code),
    .in_color        (in_ch.color),
    .in_column       (in_ch.column),
    .in_row          (in_ch.row),
    .out_cursor_col  (out_ch.cursor_col),
    .out_cursor_line (out_ch.cursor_line),
    .out_cell_word   (out_ch.cell_word)
  );

endmodule

@@ rtl/ttw_chk.sv @@
// ----------------------------------------------------------------------------
// ttw_chk : port checker of the text terminal writer
// Watches the top-level handshakes and result fields over time.
// ----------------------------------------------------------------------------
module ttw_chk #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ttw_pkg::COL_W-1:0]  cursor_col,
  input logic [ttw_pkg::LINE_W-1:0] cursor_line
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pend_r <= pend_r + 1'b1;
        2'b01:   pend_r <= pend_r - 1'b1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("item taken while the previous one is executing");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result delivered with no item outstanding");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two items outstanding");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(cursor_col) < COLS) && (32'(cursor_line) < ROWS))
    else $error("reported cursor outside the screen");

endmodule

bind text_terminal_writer_core ttw_chk #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_ttw_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cursor_col  (out_ch.cursor_col),
  .cursor_line (out_ch.cursor_line)
);
